>>> rtl/mtws_pkg.sv
// Shared constants, types and index helpers for the mutex table with wait slots.
// Used by mtws_ffs and the core; depends on nothing.
package mtws_pkg;

	localparam int NUM_MUTEXES = 128;
	localparam int WAIT_SLOTS  = 8;
	localparam int PID_BITS    = 8;

	// fixed field widths of the request and result ports
	localparam int OPC_W    = 2;
	localparam int IDX_W    = 7;
	localparam int IN_PID_W = 8;
	localparam int STATUS_W = 3;

	localparam int MIDX_W  = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
	localparam int SLOT_W  = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
	localparam int FF_PW   = ($clog2(WAIT_SLOTS) > 3) ? $clog2(WAIT_SLOTS) : 3;
	localparam int FF_W    = 1 << FF_PW;
	localparam int NCHUNK  = (NUM_MUTEXES + FF_W - 1) / FF_W;
	localparam int CH_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int ROW_W   = WAIT_SLOTS + 1;
	localparam int WADDR_W = MIDX_W + SLOT_W;
	localparam int EXT_W   = IDX_W + MIDX_W + 1;
	localparam int PEXT_W  = PID_BITS + IN_PID_W;

	typedef enum logic [OPC_W-1:0] {
		OP_CREATE = 2'd0,
		OP_LOCK   = 2'd1,
		OP_UNLOCK = 2'd2,
		OP_CLOSE  = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_QUEUED      = 3'd1,
		ST_INVALID     = 3'd2,
		ST_TABLE_FULL  = 3'd3,
		ST_WAIT_FULL   = 3'd4,
		ST_NOT_CREATOR = 3'd5
	} status_t;

	typedef struct packed {
		logic             found;
		logic [FF_PW-1:0] pos;
	} ffs_res_t;

	function automatic logic in_range(input logic [IDX_W-1:0] idx);
		logic [EXT_W-1:0] t;
		t = EXT_W'(idx);
		return t < EXT_W'(NUM_MUTEXES);
	endfunction

	function automatic logic [MIDX_W-1:0] to_midx(input logic [IDX_W-1:0] idx);
		logic [EXT_W-1:0] t;
		t = EXT_W'(idx);
		return t[MIDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] idx_out(input logic [MIDX_W-1:0] a);
		logic [EXT_W-1:0] t;
		t = EXT_W'(a);
		return t[IDX_W-1:0];
	endfunction

	function automatic logic [PID_BITS-1:0] pid_in(input logic [IN_PID_W-1:0] p);
		logic [PEXT_W-1:0] t;
		t = PEXT_W'(p);
		return t[PID_BITS-1:0];
	endfunction

	function automatic logic [IN_PID_W-1:0] pid_out(input logic [PID_BITS-1:0] p);
		logic [PEXT_W-1:0] t;
		t = PEXT_W'(p);
		return t[IN_PID_W-1:0];
	endfunction

endpackage

>>> rtl/mtws_ffs.sv
// Shared find-first-set unit: lowest set bit of one scan word.
// Depends on mtws_pkg.
module mtws_ffs (
	input  logic [mtws_pkg::FF_W-1:0] vec,
	output mtws_pkg::ffs_res_t        res
);

	always_comb begin
		res = '0;
		for (int i = mtws_pkg::FF_W - 1; i >= 0; i--) begin
			if (vec[i]) begin
				res.found = 1'b1;
				res.pos   = mtws_pkg::FF_PW'(i);
			end
		end
	end

endmodule

>>> rtl/mtws_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
module mtws_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/mutex_table_with_wait_slots_core.sv
// Mutex table with wait slots: lock, unlock with handoff, create and close.
// Steps: lock and close go start, evaluate, done; unlock adds a wake step when it
// hands off; create scans for a free entry after evaluate, 8 entries a cycle.
// Throughput: one request at a time; busy stays high until done, and the next
// start may come in the cycle done is high. The receiver cannot stall done.
// Reset: arst_n clears all control state at once; entry zero starts in use.
module mutex_table_with_wait_slots_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [mtws_pkg::OPC_W-1:0]      opcode,
	input  logic [mtws_pkg::IDX_W-1:0]      mutex_index,
	input  logic [mtws_pkg::IN_PID_W-1:0]   caller_pid,
	output logic                            done,
	output logic [mtws_pkg::STATUS_W-1:0]   status,
	output logic [mtws_pkg::IDX_W-1:0]      result_index,
	output logic                            wake_valid,
	output logic [mtws_pkg::IN_PID_W-1:0]   wake_pid
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_SCAN,
		S_WAKE
	} state_t;

	state_t                              state_q;
	mtws_pkg::opcode_t                   op_q;
	logic [mtws_pkg::IDX_W-1:0]          idx_q;
	logic [mtws_pkg::MIDX_W-1:0]         midx_q;
	logic [mtws_pkg::PID_BITS-1:0]       pid_q;
	logic [mtws_pkg::CH_W-1:0]           chunk_q;
	logic [mtws_pkg::NUM_MUTEXES-1:0]    entry_used_q;
	// Only entry zero is in use before it was ever written; these flags make
	// its row and creator read as zero until the first write lands there.
	logic                                row0_wr_q;
	logic                                cre0_wr_q;

	logic                                done_q;
	mtws_pkg::status_t                   status_q;
	logic [mtws_pkg::IDX_W-1:0]          result_index_q;
	logic                                wake_valid_q;
	logic [mtws_pkg::IN_PID_W-1:0]       wake_pid_q;

	// row memory: {lock held, wait slot occupancy mask} per entry
	logic                                row_we;
	logic [mtws_pkg::MIDX_W-1:0]         row_waddr;
	logic [mtws_pkg::ROW_W-1:0]          row_wdata;
	logic [mtws_pkg::ROW_W-1:0]          row_rdata;
	logic [mtws_pkg::ROW_W-1:0]          row_rd;
	logic                                held;
	logic [mtws_pkg::WAIT_SLOTS-1:0]     mask;

	// creator pid memory
	logic                                cre_we;
	logic [mtws_pkg::PID_BITS-1:0]       cre_rdata;
	logic [mtws_pkg::PID_BITS-1:0]       cre_rd;

	// waiter pid memory, addressed {entry, slot}
	logic                                wp_we;
	logic [mtws_pkg::WADDR_W-1:0]        wp_addr;
	logic [mtws_pkg::PID_BITS-1:0]       wp_rdata;

	// shared find-first unit
	logic [mtws_pkg::FF_W-1:0]           ffs_vec;
	mtws_pkg::ffs_res_t                  ffs_res;
	logic [mtws_pkg::NCHUNK*mtws_pkg::FF_W-1:0] free_all;
	logic [mtws_pkg::SLOT_W-1:0]         slot;
	logic [mtws_pkg::WAIT_SLOTS-1:0]     slot_bit;
	logic [mtws_pkg::CH_W+mtws_pkg::FF_PW-1:0] alloc_w;
	logic [mtws_pkg::MIDX_W-1:0]         alloc;
	logic                                entry_ok;

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign result_index = result_index_q;
	assign wake_valid   = wake_valid_q;
	assign wake_pid     = wake_pid_q;

	// Hold a never-written entry zero at its reset value.
	assign row_rd = (midx_q == '0 && !row0_wr_q) ? '0 : row_rdata;
	assign cre_rd = (midx_q == '0 && !cre0_wr_q) ? '0 : cre_rdata;
	assign held   = row_rd[mtws_pkg::WAIT_SLOTS];
	assign mask   = row_rd[mtws_pkg::WAIT_SLOTS-1:0];

	assign entry_ok = mtws_pkg::in_range(idx_q) && entry_used_q[midx_q];

	// Free entries, padded with "in use" beyond the table end.
	assign free_all = (mtws_pkg::NCHUNK * mtws_pkg::FF_W)'(~entry_used_q);

	// Feed the shared scan unit: free entries of one chunk while allocating,
	// free slots for lock, occupied slots for unlock.
	always_comb begin
		ffs_vec = '0;
		case (state_q)
			S_SCAN: ffs_vec = free_all[chunk_q*mtws_pkg::FF_W +: mtws_pkg::FF_W];
			S_EVAL: begin
				case (op_q)
					mtws_pkg::OP_LOCK:   ffs_vec = mtws_pkg::FF_W'(~mask);
					mtws_pkg::OP_UNLOCK: ffs_vec = mtws_pkg::FF_W'(mask);
					default:             ffs_vec = '0;
				endcase
			end
			default: ffs_vec = '0;
		endcase
	end

	mtws_ffs u_ffs (
		.vec (ffs_vec),
		.res (ffs_res)
	);

	assign slot     = ffs_res.pos[mtws_pkg::SLOT_W-1:0];
	assign slot_bit = mtws_pkg::WAIT_SLOTS'(1) << slot;
	assign alloc_w  = {chunk_q, ffs_res.pos};
	assign alloc    = alloc_w[mtws_pkg::MIDX_W-1:0];
	assign wp_addr  = {midx_q, slot};

	// Memory write controls.
	always_comb begin
		row_we    = 1'b0;
		row_waddr = midx_q;
		row_wdata = '0;
		cre_we    = 1'b0;
		wp_we     = 1'b0;
		case (state_q)
			S_SCAN: begin
				// new entry: clear lock and wait state, record creator
				if (ffs_res.found) begin
					row_we    = 1'b1;
					row_waddr = alloc;
					row_wdata = '0;
					cre_we    = 1'b1;
				end
			end
			S_EVAL: begin
				if (entry_ok) begin
					case (op_q)
						mtws_pkg::OP_LOCK: begin
							if (!held) begin
								row_we    = 1'b1;
								row_wdata = {1'b1, mask};
							end else if (ffs_res.found) begin
								row_we    = 1'b1;
								row_wdata = {1'b1, mask | slot_bit};
								wp_we     = 1'b1;
							end
						end
						mtws_pkg::OP_UNLOCK: begin
							row_we = 1'b1;
							if (ffs_res.found) begin
								row_wdata = {1'b1, mask & ~slot_bit};
							end else begin
								row_wdata = {1'b0, mask};
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	// Read ports sample the request index straight off the port, so the rows
	// are ready in the cycle after start.
	mtws_ram #(
		.DEPTH (mtws_pkg::NUM_MUTEXES),
		.WIDTH (mtws_pkg::ROW_W)
	) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.raddr (mtws_pkg::to_midx(mutex_index)),
		.rdata (row_rdata)
	);

	mtws_ram #(
		.DEPTH (mtws_pkg::NUM_MUTEXES),
		.WIDTH (mtws_pkg::PID_BITS)
	) u_cre_ram (
		.clk   (clk),
		.we    (cre_we),
		.waddr (alloc),
		.wdata (pid_q),
		.raddr (mtws_pkg::to_midx(mutex_index)),
		.rdata (cre_rdata)
	);

	// Waiter pids: written on a queued lock, read on a wakeup during the evaluate
	// step, ahead of the result.
	mtws_ram #(
		.DEPTH (mtws_pkg::NUM_MUTEXES * (1 << mtws_pkg::SLOT_W)),
		.WIDTH (mtws_pkg::PID_BITS)
	) u_wp_ram (
		.clk   (clk),
		.we    (wp_we),
		.waddr (wp_addr),
		.wdata (pid_q),
		.raddr (wp_addr),
		.rdata (wp_rdata)
	);

	// Sequencer: state, request latch, entry-in-use bits and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			op_q           <= mtws_pkg::OP_CREATE;
			idx_q          <= '0;
			midx_q         <= '0;
			pid_q          <= '0;
			chunk_q        <= '0;
			entry_used_q   <= mtws_pkg::NUM_MUTEXES'(1);
			row0_wr_q      <= 1'b0;
			cre0_wr_q      <= 1'b0;
			done_q         <= 1'b0;
			status_q       <= mtws_pkg::ST_OK;
			result_index_q <= '0;
			wake_valid_q   <= 1'b0;
			wake_pid_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (row_we && row_waddr == '0) begin
				row0_wr_q <= 1'b1;
			end
			if (cre_we && alloc == '0) begin
				cre0_wr_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= mtws_pkg::opcode_t'(opcode);
						idx_q   <= mutex_index;
						midx_q  <= mtws_pkg::to_midx(mutex_index);
						pid_q   <= mtws_pkg::pid_in(caller_pid);
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					// default result for a finished request: echo index, no wakeup
					result_index_q <= idx_q;
					wake_valid_q   <= 1'b0;
					wake_pid_q     <= '0;
					if (op_q == mtws_pkg::OP_CREATE) begin
						chunk_q <= '0;
						state_q <= S_SCAN;
					end else if (!entry_ok) begin
						status_q <= mtws_pkg::ST_INVALID;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						case (op_q)
							mtws_pkg::OP_LOCK: begin
								if (!held) begin
									status_q <= mtws_pkg::ST_OK;
								end else if (ffs_res.found) begin
									status_q <= mtws_pkg::ST_QUEUED;
								end else begin
									status_q <= mtws_pkg::ST_WAIT_FULL;
								end
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
							mtws_pkg::OP_UNLOCK: begin
								status_q <= mtws_pkg::ST_OK;
								if (ffs_res.found) begin
									// wait for the waiter pid read
									state_q <= S_WAKE;
								end else begin
									done_q  <= 1'b1;
									state_q <= S_IDLE;
								end
							end
							default: begin
								// close: only the creator may free the entry
								if (cre_rd == pid_q) begin
									entry_used_q[midx_q] <= 1'b0;
									status_q             <= mtws_pkg::ST_OK;
								end else begin
									status_q <= mtws_pkg::ST_NOT_CREATOR;
								end
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (ffs_res.found) begin
						entry_used_q[alloc] <= 1'b1;
						status_q            <= mtws_pkg::ST_OK;
						result_index_q      <= mtws_pkg::idx_out(alloc);
						done_q              <= 1'b1;
						state_q             <= S_IDLE;
					end else if (chunk_q == mtws_pkg::CH_W'(mtws_pkg::NCHUNK - 1)) begin
						status_q       <= mtws_pkg::ST_TABLE_FULL;
						result_index_q <= '0;
						done_q         <= 1'b1;
						state_q        <= S_IDLE;
					end else begin
						chunk_q <= chunk_q + 1'b1;
					end
				end
				S_WAKE: begin
					wake_valid_q <= 1'b1;
					wake_pid_q   <= mtws_pkg::pid_out(wp_rdata);
					done_q       <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
